// File: hdl/rtcl_pkg.sv
package rtcl_pkg;

   // continued-logarithm symbol codes
   typedef enum logic [2:0] {
      SYM_REFLECT = 3'd0,
      SYM_GROUND  = 3'd1,
      SYM_TURN    = 3'd2,
      SYM_UNCOVER = 3'd3,
      SYM_AMPLIFY = 3'd4
   } sym_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDEF = 2'd1,
      ST_ZERO  = 2'd2
   } status_type;

   // what the front end decided about an incoming ratio
   typedef enum logic [1:0] {
      KIND_RUN   = 2'd0,
      KIND_UNDEF = 2'd1,
      KIND_ZERO  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     neg;    // value is negative, sign symbol still owed
   } cls_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   localparam int MAX_RES    = 64;
   localparam int CNT_W      = $clog2(MAX_RES);
   localparam int RSP_DATA_W = 8;
   localparam int ST_W       = 2;
   localparam int QUEUE_DEPTH = 2;

endpackage

// File: hdl/ratio_to_continued_logarithm_top.sv
// signed ratio to continued-logarithm symbol expander
//
// req channel: one word per ratio, numerator and denominator as two's complement.
// rsp channel: one word per symbol; tuser carries the status, tlast marks the
// final word of a ratio's run. a 0/0 ratio gives one word with status undefined,
// a zero numerator one word with status zero, both with symbol field zero.
//
// a front end takes magnitudes and classifies each ratio, then pushes it into a
// two-entry queue; the back end pops one ratio at a time, loads its iteration
// registers and produces one symbol per cycle while rsp_tready allows, until the
// numerator is zero or MAX_RES symbols are out; special ratios skip the iteration.
// a symbol passes the queue, the iteration registers and the output word register;
// a status word skips the iteration registers.
// while the back end works, the queue keeps taking up to two more ratios.
// with rsp_tready low and a word pending, that word holds and the iteration pauses.
// synchronous reset empties the queue, drops any run and clears rsp_tvalid.
module ratio_to_continued_logarithm_top
   import rtcl_pkg::*;
#(
   parameter  int WIDTH = 16,
   localparam int REQ_W = ((2 * WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // numerator, denominator
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // symbol
   output logic [ST_W-1:0]       rsp_tuser,   // status
   output logic                  rsp_tlast
);

   localparam int Q_W = $bits(cls_type) + 2 * WIDTH;

   logic             fq_valid;
   logic             fq_ready;
   cls_type          fq_cls;
   logic [WIDTH-1:0] fq_num;
   logic [WIDTH-1:0] fq_den;
   logic             qb_valid;
   logic             qb_ready;
   logic [Q_W-1:0]   qb_data;
   cls_type          qb_cls;
   logic [WIDTH-1:0] qb_num;
   logic [WIDTH-1:0] qb_den;

   rtcl_front #(
      .WIDTH (WIDTH),
      .REQ_W (REQ_W)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_cls      (fq_cls),
      .q_num      (fq_num),
      .q_den      (fq_den)
   );

   rtcl_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  ({fq_cls, fq_num, fq_den}),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_data)
   );

   assign {qb_cls, qb_num, qb_den} = qb_data;

   rtcl_back #(
      .WIDTH (WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (qb_valid),
      .q_ready    (qb_ready),
      .q_cls      (qb_cls),
      .q_num      (qb_num),
      .q_den      (qb_den),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hdl/rtcl_front.sv
module rtcl_front
   import rtcl_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int REQ_W = 32
) (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             q_valid,
   input  logic             q_ready,
   output cls_type          q_cls,
   output logic [WIDTH-1:0] q_num,
   output logic [WIDTH-1:0] q_den
);

   logic [WIDTH-1:0] num_raw;
   logic [WIDTH-1:0] den_raw;
   logic             num_neg;
   logic             den_neg;

   assign num_raw = req_tdata[WIDTH-1:0];
   assign den_raw = req_tdata[2*WIDTH-1:WIDTH];
   assign num_neg = num_raw[WIDTH-1];
   assign den_neg = den_raw[WIDTH-1];

   // the most negative code maps to 2^(WIDTH-1), which still fits unsigned
   assign q_num = num_neg ? (~num_raw + WIDTH'(1)) : num_raw;
   assign q_den = den_neg ? (~den_raw + WIDTH'(1)) : den_raw;

   always_comb begin
      q_cls.neg = num_neg ^ den_neg;
      priority if (q_num == '0 && q_den == '0) begin
         q_cls.kind = KIND_UNDEF;
      end else if (q_num == '0) begin
         q_cls.kind = KIND_ZERO;
      end else begin
         q_cls.kind = KIND_RUN;
      end
   end

   assign q_valid    = req_tvalid;
   assign req_tready = q_ready;

endmodule

// File: hdl/rtcl_queue.sv
module rtcl_queue
   import rtcl_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  logic [DATA_W-1:0] wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output logic [DATA_W-1:0] rd_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] cnt_ff, cnt_in;
   logic              push;
   logic              pop;

   assign wr_ready = cnt_ff != CNT_QW'(QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hdl/rtcl_back.sv
module rtcl_back
   import rtcl_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  cls_type               q_cls,
   input  logic [WIDTH-1:0]      q_num,
   input  logic [WIDTH-1:0]      q_den,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [ST_W-1:0]       rsp_tuser,
   output logic                  rsp_tlast
);

   back_state_type   state_ff, state_in;
   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   sym_type          sym_ff, sym_in;
   status_type       st_ff, st_in;
   logic             last_ff, last_in;

   logic             slot_free;
   logic [WIDTH-1:0] step_num;
   logic [WIDTH-1:0] step_den;
   sym_type          step_sym;
   logic             step_done;

   assign slot_free = !valid_ff || rsp_tready;

   // one symbol of the expansion
   always_comb begin
      step_num = num_ff;
      step_den = den_ff;
      priority if (neg_ff) begin
         if (num_ff > den_ff) begin
            step_num = den_ff;
            step_den = num_ff;
            step_sym = SYM_GROUND;
         end else begin
            step_sym = SYM_REFLECT;
         end
      end else if (num_ff > den_ff) begin
         step_num = den_ff;
         step_den = num_ff;
         step_sym = SYM_TURN;
      end else if (num_ff > (den_ff >> 1)) begin
         step_num = den_ff - num_ff;
         step_den = num_ff;
         step_sym = SYM_UNCOVER;
      end else begin
         // num is at most den/2 here, so doubling cannot overflow
         if (!den_ff[0]) begin
            step_den = den_ff >> 1;
         end else begin
            step_num = {num_ff[WIDTH-2:0], 1'b0};
         end
         step_sym = SYM_AMPLIFY;
      end
      step_done = (step_num == '0) || (cnt_ff == CNT_W'(MAX_RES - 1));
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      sym_in   = sym_ff;
      st_in    = st_ff;
      last_in  = last_ff;
      q_ready  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && slot_free) begin
               q_ready = 1'b1;
               unique case (q_cls.kind)
                  KIND_UNDEF: begin
                     valid_in = 1'b1;
                     sym_in   = SYM_REFLECT;
                     st_in    = ST_UNDEF;
                     last_in  = 1'b1;
                  end
                  KIND_ZERO: begin
                     valid_in = 1'b1;
                     sym_in   = SYM_REFLECT;
                     st_in    = ST_ZERO;
                     last_in  = 1'b1;
                  end
                  default: begin
                     num_in   = q_num;
                     den_in   = q_den;
                     neg_in   = q_cls.neg;
                     cnt_in   = '0;
                     state_in = BK_RUN;
                  end
               endcase
            end
         end
         BK_RUN: begin
            if (slot_free) begin
               valid_in = 1'b1;
               sym_in   = step_sym;
               st_in    = ST_OK;
               last_in  = step_done;
               num_in   = step_num;
               den_in   = step_den;
               neg_in   = 1'b0;
               cnt_in   = cnt_ff + CNT_W'(1);
               if (step_done) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         neg_ff   <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      sym_ff  <= sym_in;
      st_ff   <= st_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(sym_type)){1'b0}}, sym_ff};
   assign rsp_tuser  = st_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: hdl/rtcl_checker.sv
module rtcl_checker
   import rtcl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [ST_W-1:0]       rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // special ratios are a single word with an empty symbol
   a_special_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tlast && (rsp_tdata == '0))
      else $error("status word not last or symbol not zero");

   // a sign symbol only opens a run, so none follows a word inside a run
   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid && (rsp_tuser == ST_OK) |->
         (rsp_tdata != RSP_DATA_W'(SYM_REFLECT)) && (rsp_tdata != RSP_DATA_W'(SYM_GROUND)))
      else $error("sign symbol inside a run");

   // reset leaves no word pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind ratio_to_continued_logarithm_top rtcl_checker u_rtcl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/ratio_to_continued_logarithm_checker.sv
module ratio_to_continued_logarithm_checker
   import rtcl_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int REQ_W = ((2 * WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // numerator, denominator
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // symbol
   input  logic [ST_W-1:0]       rsp_tuser,   // status
   input  logic                  rsp_tlast,
   output int                    mismatches,
   output int                    outstanding,
   output int                    words_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAG_W = WIDTH + 2;

   typedef struct packed {
      sym_type    symbol;
      status_type status;
      logic       last;
   } symbol_word_type;

   symbol_word_type pending_words[$];
   int fail_count = 0;
   int word_count = 0;
   int queue_size = 0;

   assign mismatches    = fail_count;
   assign outstanding   = queue_size;
   assign words_checked = word_count;

   function automatic logic [MAG_W-1:0] magnitude_of(input logic [WIDTH-1:0] raw);
      logic [WIDTH-1:0] inv;
      inv = ~raw;
      if (raw[WIDTH-1]) begin
         return {2'b00, inv} + 1'b1;
      end
      return {2'b00, raw};
   endfunction

   // whole expansion of one ratio, pushed word by word
   task automatic expand_ratio(input logic [WIDTH-1:0] num_raw, input logic [WIDTH-1:0] den_raw);
      logic [MAG_W-1:0] n;
      logic [MAG_W-1:0] d;
      logic [MAG_W-1:0] t;
      logic             owe_sign;
      logic             done;
      sym_type          s;
      int               count;
      n = magnitude_of(num_raw);
      d = magnitude_of(den_raw);
      if (n == 0 && d == 0) begin
         pending_words.push_back('{SYM_REFLECT, ST_UNDEF, 1'b1});
      end else if (n == 0) begin
         pending_words.push_back('{SYM_REFLECT, ST_ZERO, 1'b1});
      end else begin
         owe_sign = num_raw[WIDTH-1] ^ den_raw[WIDTH-1];
         count = 0;
         done = 1'b0;
         while (!done) begin
            if (owe_sign) begin
               owe_sign = 1'b0;
               if (n > d) begin
                  t = n; n = d; d = t;
                  s = SYM_GROUND;
               end else begin
                  s = SYM_REFLECT;
               end
            end else if (n > d) begin
               t = n; n = d; d = t;
               s = SYM_TURN;
            end else if (n > (d >> 1)) begin
               t = n;
               n = d - t;
               d = t;
               s = SYM_UNCOVER;
            end else begin
               if (!d[0]) begin
                  d = d >> 1;
               end else begin
                  n = n << 1;
               end
               s = SYM_AMPLIFY;
            end
            count++;
            // overlong runs are cut with last set on the final kept word
            done = (n == 0) || (count >= MAX_RES);
            pending_words.push_back('{s, ST_OK, done});
         end
      end
   endtask

   always @(posedge clock) begin
      symbol_word_type want;
      if (reset) begin
         pending_words.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expand_ratio(req_tdata[WIDTH-1:0], req_tdata[2*WIDTH-1:WIDTH]);
         end
         if (rsp_tvalid && rsp_tready) begin
            word_count++;
            if (pending_words.size() == 0) begin
               $error("unexpected word: symbol %0d status %0d last %0d",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(want.symbol)) begin
                  $error("symbol: expected %0d, got %0d", want.symbol, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      queue_size = pending_words.size();
   end

endmodule

// File: sim/ratio_to_continued_logarithm_top_tb.sv
module ratio_to_continued_logarithm_top_tb;
   import rtcl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH       = 16;
   localparam int REQ_W       = ((2 * WIDTH + 7) / 8) * 8;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 80;
   localparam int RANDOM_RATIOS = 200;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;   // numerator, denominator
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // symbol
   logic [ST_W-1:0]       rsp_tuser;   // status
   logic                  rsp_tlast;

   int mismatches;
   int outstanding;
   int words_checked;

   int burst_left = 0;
   int directed_sent = 0;
   int random_sent = 0;
   int idle_cycles = 0;
   logic start_hold = 1'b0;

   always #1 clock = ~clock;

   ratio_to_continued_logarithm_top #(.WIDTH(WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ratio_to_continued_logarithm_checker #(.WIDTH(WIDTH), .REQ_W(REQ_W)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   // offer one ratio, with a random gap whenever a burst runs out
   task automatic send_ratio(input logic [WIDTH-1:0] num, input logic [WIDTH-1:0] den);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({den, num});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [WIDTH-1:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         return '0;
      end
      if (sel < 16) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'h0001;
         endcase
      end
      if (sel < 40) begin
         return WIDTH'($urandom_range(0, 32) - 16);
      end
      return WIDTH'($urandom);
   endfunction

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero over zero, zero value, zero denominator, extremes, both signs
      send_ratio(16'h0000, 16'h0000);
      send_ratio(16'h0000, 16'h0005);
      send_ratio(16'h0000, 16'hfffb);
      send_ratio(16'h0000, 16'h8000);
      send_ratio(16'h0005, 16'h0000);
      send_ratio(16'hfffb, 16'h0000);
      send_ratio(16'h8000, 16'h0000);
      send_ratio(16'h7fff, 16'h7fff);
      send_ratio(16'h8000, 16'h8000);
      send_ratio(16'h8000, 16'h7fff);
      send_ratio(16'h7fff, 16'h8000);
      send_ratio(16'h0001, 16'h0001);
      send_ratio(16'hffff, 16'h0001);
      send_ratio(16'h0001, 16'hffff);
      send_ratio(16'h0003, 16'h0007);
      send_ratio(16'h0007, 16'h0003);
      send_ratio(16'hfff9, 16'h0003);
      send_ratio(16'h7fff, 16'h0001);
      send_ratio(16'h0001, 16'h7fff);
      send_ratio(16'h8000, 16'h0001);
      send_ratio(16'h0001, 16'h8000);
      send_ratio(16'd12345, 16'hE57B);
      send_ratio(16'd100, 16'd200);
      directed_sent = 23;

      start_hold = 1'b1;
      repeat (RANDOM_RATIOS) begin
         if ($urandom_range(0, 19) == 0) begin
            send_ratio('0, '0);
         end else begin
            send_ratio(pick_operand(), pick_operand());
         end
         random_sent++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d directed and %0d random ratios, compared %0d symbol words",
               directed_sent, random_sent, words_checked);
      $display("receiver stalled at random and held off %0d cycles once to back up the input",
               HOLD_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("ratio_to_continued_logarithm_top_tb OK");
      end else begin
         $display("ratio_to_continued_logarithm_top_tb NOT OK");
      end
      $finish;
   end

   // receiver: segments of different stall patterns, plus one long hold-off
   initial begin
      int mode;
      int len;
      int phase;
      logic hold_done;
      rsp_tready = 1'b0;
      hold_done = 1'b0;
      phase = 0;
      forever begin
         if (start_hold && !hold_done) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(10, 120);
         repeat (len) begin
            @(negedge clock);
            phase++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (phase % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no word moved for %0d cycles", IDLE_LIMIT);
            $display("ratio_to_continued_logarithm_top_tb NOT OK");
            $finish;
         end
      end
   end

endmodule
